/* rtl/core/adi_pkg.sv */
// shared widths, register indexes and the adc/distance lookup rom for the distance interpolator
package adi_pkg;

  localparam int unsigned AdcW    = 12;
  localparam int unsigned DistW   = 16;
  localparam int unsigned ProdW   = AdcW + DistW;
  localparam int unsigned RomSize = 40;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgMinSample = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxSample = 2'd1;

  localparam logic [AdcW-1:0] MinSampleRst = 12'd562;
  localparam logic [AdcW-1:0] MaxSampleRst = 12'd3773;

  typedef struct packed {
    logic [AdcW-1:0]  adc;
    logic [DistW-1:0] dist_val;
  } rom_entry_t;

  // adc readings descend while distances ascend
  localparam rom_entry_t AdiRom [RomSize] = '{
    '{12'd3733, 16'd7000},  '{12'd3393, 16'd8000},  '{12'd3077, 16'd9000},
    '{12'd2798, 16'd10000}, '{12'd2584, 16'd11000}, '{12'd2361, 16'd12000},
    '{12'd2181, 16'd13000}, '{12'd2044, 16'd14000}, '{12'd1926, 16'd15000},
    '{12'd1811, 16'd16000}, '{12'd1708, 16'd17000}, '{12'd1646, 16'd18000},
    '{12'd1553, 16'd19000}, '{12'd1482, 16'd20000}, '{12'd1411, 16'd21000},
    '{12'd1341, 16'd22000}, '{12'd1294, 16'd23000}, '{12'd1231, 16'd24000},
    '{12'd1190, 16'd25000}, '{12'd1124, 16'd26000}, '{12'd1099, 16'd27000},
    '{12'd1051, 16'd28000}, '{12'd1004, 16'd29000}, '{12'd980,  16'd30000},
    '{12'd933,  16'd31000}, '{12'd909,  16'd32000}, '{12'd882,  16'd33000},
    '{12'd858,  16'd34000}, '{12'd833,  16'd35000}, '{12'd808,  16'd36000},
    '{12'd784,  16'd37000}, '{12'd760,  16'd38000}, '{12'd736,  16'd39000},
    '{12'd733,  16'd40000}, '{12'd687,  16'd42500}, '{12'd645,  16'd45000},
    '{12'd615,  16'd47500}, '{12'd591,  16'd50000}, '{12'd568,  16'd52500},
    '{12'd562,  16'd55000}
  };

endpackage

/* rtl/core/adc_to_distance_interpolator.sv */
// adc sample to distance converter: rom walk for the bracketing pair, then linear interpolation
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------
//   in      | input     | in_valid_i/in_stall_o | adc_sample_i
//   out     | output    | out_valid_o/out_stall_i | distance_o, valid_res_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_wdata_i
//
// a sample outside the window goes straight to the done state and then, once the output
// is free, into the output register; an in-window sample goes through the rom walk, which
// reads one entry per cycle from a registered rom port (if no pair brackets the sample,
// it goes to the done state with an invalid result), then the multiply state, the restoring
// divide and its done flag (skipped for a flat or falling pair), and the output register
// one sample is in work at a time; the output register holds a result while the next
// sample is taken; async active-low reset restores the window limits
module adc_to_distance_interpolator #(
  parameter int unsigned TABLE_ENTRIES = 40,
  parameter int unsigned SAMPLE_BITS   = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SAMPLE_BITS-1:0]      adc_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [adi_pkg::DistW-1:0]   distance_o,
  output logic                        valid_res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [adi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]      cfg_wdata_i
);
  import adi_pkg::*;

  localparam int unsigned Entries = (TABLE_ENTRIES > RomSize) ? RomSize : TABLE_ENTRIES;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CmpW    = (SAMPLE_BITS > AdcW) ? SAMPLE_BITS : AdcW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWalk = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]       state_q;
  logic [CmpW-1:0]  min_q, max_q;
  logic [CmpW-1:0]  sample_q;
  logic [IdxW-1:0]  addr_q, rd_idx_q;
  logic             rd_vld_q;
  rom_entry_t       rom_q, prev_q;
  logic [DistW-1:0] d0_q, dd_q;
  logic [AdcW-1:0]  den_q, delta_q;
  logic             skip_q;
  logic [DistW-1:0] res_dist_q;
  logic             res_ok_q;
  logic             out_valid_q;
  logic [DistW-1:0] out_dist_q;
  logic             out_ok_q;

  logic [CmpW-1:0]  samp_in;
  logic             in_win;
  logic             bracket;
  logic             out_free;
  logic             div_start, div_done;
  logic [ProdW-1:0] div_dividend;
  logic [DistW-1:0] div_quo;

  assign samp_in  = CmpW'(adc_sample_i);
  assign in_win   = (samp_in >= min_q) && (samp_in <= max_q);
  assign bracket  = (CmpW'(prev_q.adc) >= sample_q) && (CmpW'(rom_q.adc) <= sample_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = state_q != StIdle;
  assign cfg_ready_o = 1'b1;

  // registered rom read port
  always_ff @(posedge clk_i) begin
    rom_q <= AdiRom[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= CmpW'(MinSampleRst);
      max_q <= CmpW'(MaxSampleRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgMinSample: min_q <= CmpW'(cfg_wdata_i);
        CfgMaxSample: max_q <= CmpW'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      addr_q     <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      sample_q   <= '0;
      prev_q     <= '0;
      d0_q       <= '0;
      dd_q       <= '0;
      den_q      <= '0;
      delta_q    <= '0;
      skip_q     <= 1'b0;
      res_dist_q <= '0;
      res_ok_q   <= 1'b0;
    end else begin
      rd_vld_q <= state_q == StWalk;
      rd_idx_q <= addr_q;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            sample_q <= samp_in;
            addr_q   <= '0;
            if (in_win) begin
              state_q <= StWalk;
            end else begin
              res_dist_q <= '0;
              res_ok_q   <= 1'b0;
              state_q    <= StDone;
            end
          end
        end
        StWalk: begin
          if (addr_q != LastIdx) begin
            addr_q <= addr_q + IdxW'(1);
          end
          if (rd_vld_q) begin
            if (rd_idx_q == '0) begin
              prev_q <= rom_q;
            end else if (bracket) begin
              d0_q    <= prev_q.dist_val;
              dd_q    <= rom_q.dist_val - prev_q.dist_val;
              den_q   <= prev_q.adc - rom_q.adc;
              delta_q <= AdcW'(CmpW'(prev_q.adc) - sample_q);
              skip_q  <= (prev_q.adc == rom_q.adc) || (rom_q.dist_val < prev_q.dist_val);
              state_q <= StMul;
            end else begin
              prev_q <= rom_q;
              if (rd_idx_q == LastIdx) begin
                res_dist_q <= '0;
                res_ok_q   <= 1'b0;
                state_q    <= StDone;
              end
            end
          end
        end
        StMul: begin
          if (skip_q) begin
            res_dist_q <= d0_q;
            res_ok_q   <= 1'b1;
            state_q    <= StDone;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            res_dist_q <= d0_q + div_quo;
            res_ok_q   <= 1'b1;
            state_q    <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // product lands straight in the divider's dividend register
  assign div_start    = (state_q == StMul) && !skip_q;
  assign div_dividend = ProdW'(dd_q) * ProdW'(delta_q);

  adi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_dist_q  <= '0;
      out_ok_q    <= 1'b0;
    end else if ((state_q == StDone) && out_free) begin
      out_valid_q <= 1'b1;
      out_dist_q  <= res_dist_q;
      out_ok_q    <= res_ok_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign valid_res_o = out_ok_q;

endmodule

/* rtl/core/adi_div.sv */
// restoring divider, one quotient bit per cycle
module adi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [adi_pkg::ProdW-1:0] dividend_i,
  input  logic [adi_pkg::AdcW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [adi_pkg::DistW-1:0] quotient_o
);
  import adi_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic [AdcW-1:0]   rem_q;
  logic [ProdW-1:0]  quo_q;
  logic [AdcW-1:0]   dvs_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [AdcW:0]     rem_sh;
  logic [AdcW:0]     rem_sub;
  logic              ge;

  // remainder stays below the divisor, so it fits in AdcW bits
  assign rem_sh  = {rem_q, quo_q[ProdW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(ProdW);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[AdcW-1:0] : rem_sh[AdcW-1:0];
        quo_q <= {quo_q[ProdW-2:0], ge};
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // quotient never exceeds the distance step, so the low bits carry it all
  assign done_o     = done_q;
  assign quotient_o = quo_q[DistW-1:0];

endmodule

/* rtl/core/adi_checker.sv */
// port-level checks for the distance interpolator, bound to the top level
module adi_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [adi_pkg::DistW-1:0]   distance_o,
  input logic                        valid_res_o
);

  // a held result keeps its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o) && $stable(valid_res_o))
    else $error("stalled result changed");

  // rejected samples report zero distance
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> distance_o == '0)
    else $error("invalid result with nonzero distance");

  // one sample in work at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is in work");

  // no result can appear in the cycle right after a sample beat
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind adc_to_distance_interpolator adi_checker u_adi_checker (.*);
